// File: rtl/core/int32_to_decimal_ascii_unit_macros.svh
// ---------------------------------------------------------------------------
// int32_to_decimal_ascii_unit_macros.svh
// Assertion macros for the integer-to-decimal-text unit.
// ---------------------------------------------------------------------------
`ifndef INT32_TO_DECIMAL_ASCII_UNIT_MACROS_SVH
`define INT32_TO_DECIMAL_ASCII_UNIT_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled during reset.
`define I2DA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("i2da assertion failed");
// Next-cycle implication, disabled during reset.
`define I2DA_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("i2da assertion failed");
`else
`define I2DA_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define I2DA_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

// File: rtl/core/i2da_pkg.sv
// ---------------------------------------------------------------------------
// i2da_pkg
// Types, character codes and decimal weights for the integer-to-text unit.
// ---------------------------------------------------------------------------
`default_nettype none

package i2da_pkg;

    localparam int NUM_DIGITS = 10;
    localparam int POS_W      = 4;

    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;

    typedef logic [31:0]      t_value;
    typedef logic [3:0]       t_digit;
    typedef logic [POS_W-1:0] t_pos;
    typedef t_digit [NUM_DIGITS-1:0] t_digit_row;

    localparam t_pos LAST_POS = t_pos'(NUM_DIGITS - 1);

    // decimal weight of each position, most significant first
    localparam logic [35:0] POW10 [NUM_DIGITS] = '{
        36'd1000000000, 36'd100000000, 36'd10000000, 36'd1000000, 36'd100000,
        36'd10000, 36'd1000, 36'd100, 36'd10, 36'd1
    };

    // m times the weight of position pos; only called with constant arguments
    function automatic logic [35:0] digit_weight(input int pos, input int m);
        return POW10[pos] * 36'(m);
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/int32_to_decimal_ascii_unit.sv
// ---------------------------------------------------------------------------
// int32_to_decimal_ascii_unit
// Converts signed 32-bit integers to decimal ASCII text, one character per
// output item, with a last flag on the final character of each value.
// ---------------------------------------------------------------------------
//
//  Channel | Direction | Handshake                | Payload
//  --------+-----------+--------------------------+--------------------------
//  input   | in        | i_in_valid / o_in_ready  | i_value (32b signed)
//  output  | out       | o_out_valid / i_out_ready| o_character (8b), o_last
//
// One stage takes the magnitude, then ten stages each peel off one decimal
// digit (nine parallel compares against the digit weights and a subtract).
// A value enters every cycle while the pipe moves; the first character shows
// after stages 0 to 10 and the serializer register, which sits at the end and
// emits one character per cycle while i_out_ready is high, so a value costs 1
// to 11 characters (sign plus digits) and the output port sets the sustained
// rate. Reset (synchronous, active low) clears all valid bits. A stall on the
// output holds the serializer; stages fill up behind it and then drop ready.
// ---------------------------------------------------------------------------
`default_nettype none

`include "int32_to_decimal_ascii_unit_macros.svh"

module int32_to_decimal_ascii_unit (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    output      logic            o_in_ready,
    input  wire i2da_pkg::t_value i_value,
    output      logic            o_out_valid,
    input  wire logic            i_out_ready,
    output      logic [7:0]      o_character,
    output      logic            o_last
);
    import i2da_pkg::*;

    localparam int LAST_STAGE = NUM_DIGITS;

    // pipeline stage registers: stage 0 holds the magnitude, stage k holds
    // digits 0..k-1 and the remainder still to convert
    logic       r_valid   [0:LAST_STAGE];
    t_value     r_mag     [0:LAST_STAGE];
    logic       r_neg     [0:LAST_STAGE];
    t_digit_row r_dig     [0:LAST_STAGE];
    logic       r_started [0:LAST_STAGE];
    t_pos       r_first   [0:LAST_STAGE];

    t_value     n_mag     [1:LAST_STAGE];
    t_digit_row n_dig     [1:LAST_STAGE];
    logic       n_started [1:LAST_STAGE];
    t_pos       n_first   [1:LAST_STAGE];

    logic       stage_ready [0:LAST_STAGE+1];

    // character serializer
    logic       r_ser_valid;
    logic       r_ser_neg;
    t_pos       r_ser_idx;
    t_digit_row r_ser_dig;
    logic       ser_free;

    // ---------------------------------------------------------------------
    // Digit extraction: one digit per stage
    // ---------------------------------------------------------------------
    always_comb begin
        t_digit      d;
        logic [31:0] sub;
        logic [35:0] w;
        for (int k = 1; k <= LAST_STAGE; k++) begin
            d   = '0;
            sub = '0;
            for (int m = 1; m <= 9; m++) begin
                w = digit_weight(k - 1, m);
                if ({4'b0, r_mag[k-1]} >= w) begin
                    d   = t_digit'(m);
                    sub = w[31:0];
                end
            end
            n_mag[k]        = r_mag[k-1] - sub;
            n_dig[k]        = r_dig[k-1];
            n_dig[k][k-1]   = d;
            n_started[k]    = r_started[k-1] || (d != '0);
            n_first[k]      = r_started[k-1] ? r_first[k-1] : t_pos'(k - 1);
        end
    end

    // ---------------------------------------------------------------------
    // Flow control: a stage takes new data when it is empty or moves on
    // ---------------------------------------------------------------------
    assign ser_free = !r_ser_valid || (i_out_ready && o_last);

    always_comb begin
        stage_ready[LAST_STAGE+1] = ser_free;
        for (int k = LAST_STAGE; k >= 0; k--) begin
            stage_ready[k] = !r_valid[k] || stage_ready[k+1];
        end
    end

    assign o_in_ready = stage_ready[0];

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= LAST_STAGE; k++) begin
                r_valid[k] <= 1'b0;
            end
        end else begin
            if (stage_ready[0]) begin
                r_valid[0] <= i_in_valid;
            end
            for (int k = 1; k <= LAST_STAGE; k++) begin
                if (stage_ready[k]) begin
                    r_valid[k] <= r_valid[k-1];
                end
            end
        end
    end

    // stage payload
    always_ff @(posedge i_clk) begin
        if (stage_ready[0]) begin
            r_neg[0]     <= i_value[31];
            r_mag[0]     <= i_value[31] ? (32'd0 - i_value) : i_value;
            r_dig[0]     <= '0;
            r_started[0] <= 1'b0;
            r_first[0]   <= '0;
        end
        for (int k = 1; k <= LAST_STAGE; k++) begin
            if (stage_ready[k]) begin
                r_neg[k]     <= r_neg[k-1];
                r_mag[k]     <= n_mag[k];
                r_dig[k]     <= n_dig[k];
                r_started[k] <= n_started[k];
                r_first[k]   <= n_first[k];
            end
        end
    end

    // ---------------------------------------------------------------------
    // Serializer: sign first, then digits from the first nonzero one
    // ---------------------------------------------------------------------
    assign o_out_valid = r_ser_valid;
    assign o_last      = !r_ser_neg && (r_ser_idx == LAST_POS);
    assign o_character = r_ser_neg ? CHAR_MINUS : (CHAR_ZERO + {4'b0, r_ser_dig[r_ser_idx]});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ser_valid <= 1'b0;
            r_ser_neg   <= 1'b0;
        end else if (ser_free) begin
            r_ser_valid <= r_valid[LAST_STAGE];
            r_ser_neg   <= r_neg[LAST_STAGE];
        end else if (i_out_ready && r_ser_neg) begin
            r_ser_neg   <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ser_free) begin
            r_ser_dig <= r_dig[LAST_STAGE];
            // zero has no nonzero digit: emit the units digit alone
            r_ser_idx <= r_started[LAST_STAGE] ? r_first[LAST_STAGE] : LAST_POS;
        end else if (r_ser_valid && i_out_ready && !r_ser_neg) begin
            r_ser_idx <= r_ser_idx + t_pos'(1);
        end
    end

    // ---------------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------------
    // a run never breaks off before its last character
    `I2DA_ASSERT_NXT(a_run_continues, i_clk, i_rst_n,
        o_out_valid && i_out_ready && !o_last, o_out_valid)
    // the first emitted digit of a nonzero value is never a zero
    `I2DA_ASSERT_IMP(a_no_leading_zero, i_clk, i_rst_n,
        r_valid[LAST_STAGE] && r_started[LAST_STAGE],
        r_dig[LAST_STAGE][r_first[LAST_STAGE]] != '0)
    // magnitude fits the unsigned range implied by the sign
    `I2DA_ASSERT_IMP(a_mag_range, i_clk, i_rst_n,
        r_valid[0] && !r_neg[0], !r_mag[0][31])

endmodule

`default_nettype wire
